### hdl/rtsp_pkg.sv
// Package for the resistive touch sample processor.
// Field widths, register map codes and reset values; no dependencies.
`timescale 1ns / 1ps

package rtsp_pkg;

  localparam int SAMPLE_W      = 12;  // converter sample width
  localparam int RES_FRAC_BITS = 7;   // fraction bits of the touch resistance
  localparam int RATIO_W       = SAMPLE_W + RES_FRAC_BITS;
  localparam int LIMIT_W       = 16;
  localparam int THR_W         = 12;
  localparam int DB_W          = 10;
  localparam int STR_W         = 13;
  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 4;

  typedef enum logic [1:0] {
    REG_WIDTH_LIMIT,
    REG_HEIGHT_LIMIT,
    REG_PRESS_THRESHOLD,
    REG_EDGE_DEADBAND
  } reg_idx_t;

  localparam logic [LIMIT_W-1:0] WIDTH_LIMIT_RST     = 16'd320;
  localparam logic [LIMIT_W-1:0] HEIGHT_LIMIT_RST    = 16'd240;
  localparam logic [THR_W-1:0]   PRESS_THRESHOLD_RST = 12'd2000;
  localparam logic [DB_W-1:0]    EDGE_DEADBAND_RST   = 10'd300;

endpackage

### hdl/resistive_touch_sample_processor_core.sv
// Resistive touch sample processor: pressure check and coordinate scaling.
// Single-module pipeline with APB-style register port; uses rtsp_pkg.
`timescale 1ns / 1ps

// While out_stall is low, one sample set (X, Y, Z1, Z2) enters per cycle and its
// result leaves via the output register, one transfer per cycle each way. The
// depth is set by the Z2*128/Z1 restoring divider, which resolves two of its
// 19 quotient bits per stage; the two coordinate dividers (16 quotient bits,
// two per stage) run alongside it, followed by one multiply stage and one
// compare stage that fills the output register. A stall on the result side
// only holds the occupied stages: empty stages keep filling, so input is
// still taken while a result waits, until every stage holds an item.
// Registers (byte address 4*i): width_limit, height_limit, press_threshold,
// edge_deadband. Write them only while no result is outstanding.
module resistive_touch_sample_processor_core #(
  parameter int ADC_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rtsp_pkg::SAMPLE_W-1:0] in_raw_x,
  input  logic [rtsp_pkg::SAMPLE_W-1:0] in_raw_y,
  input  logic [rtsp_pkg::SAMPLE_W-1:0] in_raw_z1,
  input  logic [rtsp_pkg::SAMPLE_W-1:0] in_raw_z2,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_touched,
  output logic [rtsp_pkg::LIMIT_W-1:0]  out_pos_x,
  output logic [rtsp_pkg::LIMIT_W-1:0]  out_pos_y,
  output logic [rtsp_pkg::STR_W-1:0]    out_strength,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rtsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [rtsp_pkg::DATA_W-1:0]   pwdata,
  output logic [rtsp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int AB  = ADC_BITS;
  localparam int SPW = ((AB > rtsp_pkg::DB_W + 1) ? AB : rtsp_pkg::DB_W + 1) + 2;
  localparam int SW  = rtsp_pkg::SAMPLE_W;
  localparam int LW  = rtsp_pkg::LIMIT_W;
  localparam int RW  = rtsp_pkg::RATIO_W;

  localparam int STEPS_PER = 2;
  localparam int RD_ST     = (RW + STEPS_PER - 1) / STEPS_PER;  // ratio divider stages
  localparam int AX_ST     = (LW + STEPS_PER - 1) / STEPS_PER;  // axis divider stages
  localparam int MUL_K     = RD_ST + 2;
  localparam int NS        = RD_ST + 3;

  localparam logic [SPW-1:0] FULL = {{(SPW-1){1'b0}}, 1'b1} << AB;
  localparam logic [31:0]    BIAS = (32'd1 << AB) - 32'd1;

  typedef struct packed {
    logic                     nz;       // z1 nonzero
    logic                     span_ok;  // deadband leaves a window
    logic [SW-1:0]            x;
    logic [SW-1:0]            z1;
    logic [SW:0]              rrem;
    logic [RW-1:0]            rq;
    logic [AB-1:0]            sx;
    logic [AB-1:0]            sy;
    logic [AB+LW:0]           xa;       // {remainder, quotient} of the X divider
    logic [AB+LW:0]           ya;
    logic signed [31:0]       rprod;
    logic                     touched;
    logic [LW-1:0]            pos_x;
    logic [LW-1:0]            pos_y;
    logic [rtsp_pkg::STR_W-1:0] strength;
  } stage_t;

  // ---------------- registers ----------------
  logic [LW-1:0]               width_r;
  logic [LW-1:0]               height_r;
  logic [rtsp_pkg::THR_W-1:0]  thr_r;
  logic [rtsp_pkg::DB_W-1:0]   db_r;

  logic                        wr_en;
  rtsp_pkg::reg_idx_t          wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign wr_idx = rtsp_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= rtsp_pkg::WIDTH_LIMIT_RST;
      height_r <= rtsp_pkg::HEIGHT_LIMIT_RST;
      thr_r    <= rtsp_pkg::PRESS_THRESHOLD_RST;
      db_r     <= rtsp_pkg::EDGE_DEADBAND_RST;
    end else if (wr_en) begin
      unique case (wr_idx)
        rtsp_pkg::REG_WIDTH_LIMIT:     width_r  <= pwdata[LW-1:0];
        rtsp_pkg::REG_HEIGHT_LIMIT:    height_r <= pwdata[LW-1:0];
        rtsp_pkg::REG_PRESS_THRESHOLD: thr_r    <= pwdata[rtsp_pkg::THR_W-1:0];
        rtsp_pkg::REG_EDGE_DEADBAND:   db_r     <= pwdata[rtsp_pkg::DB_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (rtsp_pkg::reg_idx_t'(paddr[3:2]))
      rtsp_pkg::REG_WIDTH_LIMIT:     prdata = 32'(width_r);
      rtsp_pkg::REG_HEIGHT_LIMIT:    prdata = 32'(height_r);
      rtsp_pkg::REG_PRESS_THRESHOLD: prdata = 32'(thr_r);
      rtsp_pkg::REG_EDGE_DEADBAND:   prdata = 32'(db_r);
    endcase
  end

  // ---------------- deadband window ----------------
  logic signed [SPW-1:0] db_s;
  logic signed [SPW-1:0] span_s;
  logic signed [SPW-1:0] hi_s;
  logic                  span_ok;
  logic [AB:0]           span_u;

  assign db_s    = $signed(SPW'(db_r));
  assign span_s  = $signed(FULL - (SPW'(db_r) << 1));
  assign hi_s    = $signed(FULL - SPW'(db_r) - SPW'(1));
  assign span_ok = span_s > 0;
  assign span_u  = span_s[AB:0];

  function automatic logic [AB-1:0] clamp_off(input logic [SW-1:0] v,
                                              input logic signed [SPW-1:0] lo,
                                              input logic signed [SPW-1:0] hi);
    logic signed [SPW-1:0] s;
    s = $signed(SPW'(v));
    if (s < lo) s = lo;
    else if (s > hi) s = hi;
    return AB'(s - lo);
  endfunction

  // one restoring step of a coordinate divider
  function automatic logic [AB+LW:0] ax_step(input logic [AB+LW:0] a,
                                             input logic [AB:0] dv);
    logic [AB:0]   rem;
    logic [LW-1:0] q;
    logic          ge;
    rem = {a[AB+LW-1:LW], a[LW-1]};
    ge  = rem >= dv;
    q   = {a[LW-2:0], ge};
    if (ge) rem = rem - dv;
    return {rem, q};
  endfunction

  function automatic stage_t stage_next(input stage_t s, input int k,
                                        input logic ok_unused_guard,
                                        input logic [AB:0] dv,
                                        input logic [LW-1:0] wl,
                                        input logic [LW-1:0] hl,
                                        input logic [rtsp_pkg::THR_W-1:0] thr);
    stage_t             n;
    logic [SW:0]        rr;
    logic [RW-1:0]      rq;
    logic               ge;
    logic [AB+LW:0]     xa;
    logic [AB+LW:0]     ya;
    logic signed [31:0] xs;
    logic signed [31:0] rs;
    logic signed [31:0] t;
    logic signed [31:0] thr_s;
    n = '0;
    n.nz      = s.nz;
    n.span_ok = s.span_ok & ok_unused_guard;
    if (k < MUL_K) n.x = s.x;

    // ratio divider: Z2*128 / Z1
    if (k <= RD_ST + 1) begin
      rr = s.rrem;
      rq = s.rq;
      for (int j = 0; j < STEPS_PER; j++) begin
        if (STEPS_PER * (k - 2) + j < RW) begin
          rr = {rr[SW-1:0], rq[RW-1]};
          ge = rr >= {1'b0, s.z1};
          rq = {rq[RW-2:0], ge};
          if (ge) rr = rr - {1'b0, s.z1};
        end
      end
      n.rq = rq;
      if (k < RD_ST + 1) begin
        n.rrem = rr;
        n.z1   = s.z1;
      end
    end

    // coordinate scaling: product, then divide by the window span
    if (k == 2) begin
      n.xa = {1'b0, ({{LW{1'b0}}, s.sx} * {{AB{1'b0}}, wl})};
      n.ya = {1'b0, ({{LW{1'b0}}, s.sy} * {{AB{1'b0}}, hl})};
    end else if (k <= 2 + AX_ST) begin
      xa = s.xa;
      ya = s.ya;
      for (int j = 0; j < STEPS_PER; j++) begin
        if (STEPS_PER * (k - 3) + j < LW) begin
          xa = ax_step(xa, dv);
          ya = ax_step(ya, dv);
        end
      end
      n.xa = xa;
      n.ya = ya;
    end else if (k < NS) begin
      n.xa = s.xa;
      n.ya = s.ya;
    end

    if (k == MUL_K) begin
      xs = 32'($signed({1'b0, s.x}));
      rs = 32'($signed({1'b0, s.rq})) - 32'sd128;
      n.rprod = xs * rs;
    end

    if (k == NS) begin
      // divide by 2^ADC_BITS, truncating toward zero
      t = s.rprod;
      if (t[31]) t = t + $signed(BIAS);
      t = t >>> AB;
      thr_s = $signed(32'(thr));
      n.touched  = s.nz && (t < thr_s);
      n.strength = n.touched ? rtsp_pkg::STR_W'(thr_s - t) : '0;
      n.pos_x    = s.span_ok ? s.xa[LW-1:0] : '0;
      n.pos_y    = s.span_ok ? s.ya[LW-1:0] : '0;
    end
    return n;
  endfunction

  // ---------------- pipeline ----------------
  stage_t      p_r   [1:NS];
  stage_t      p_nxt [1:NS];
  logic [NS:1] v_r;
  logic [NS:1] v_nxt;
  logic [NS:1] rdy;

  // a stage loads when it is empty or its occupant moves on
  always_comb begin
    rdy[NS] = !v_r[NS] || !out_stall;
    for (int k = NS - 1; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[1];

  always_comb begin
    p_nxt[1]         = '0;
    p_nxt[1].nz      = in_raw_z1 != '0;
    p_nxt[1].span_ok = span_ok;
    p_nxt[1].x       = in_raw_x;
    p_nxt[1].z1      = in_raw_z1;
    p_nxt[1].rq      = {in_raw_z2, {rtsp_pkg::RES_FRAC_BITS{1'b0}}};
    p_nxt[1].sx      = clamp_off(in_raw_x, db_s, hi_s);
    p_nxt[1].sy      = clamp_off(in_raw_y, db_s, hi_s);
    for (int k = 2; k <= NS; k++) begin
      p_nxt[k] = stage_next(p_r[k-1], k, 1'b1, span_u, width_r, height_r, thr_r);
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (rdy[1]) v_nxt[1] = in_valid;
    for (int k = 2; k <= NS; k++) begin
      if (rdy[k]) v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NS; k++) begin
      if (rdy[k]) p_r[k] <= p_nxt[k];
    end
  end

  assign out_valid    = v_r[NS];
  assign out_touched  = p_r[NS].touched;
  assign out_pos_x    = p_r[NS].pos_x;
  assign out_pos_y    = p_r[NS].pos_y;
  assign out_strength = p_r[NS].strength;

  // ---------------- assertions ----------------
  a_no_touch_zero_strength: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_touched |-> out_strength == '0)
    else $error("strength set without a touch");

  a_touch_has_strength: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_touched |-> out_strength != '0)
    else $error("touch reported with zero strength");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> &v_r)
    else $error("input stalled while a pipeline stage is empty");

endmodule
